// ----- rtl/bbcs_pkg.sv -----
`default_nettype none
package bbcs_pkg;

  // fixed field widths
  localparam int VAL_W = 16;
  localparam int CFG_IDX_W = 1;

  // default level width
  localparam int DUTY_BITS_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

  // register reset values
  localparam logic [VAL_W-1:0] PERIOD_RST   = 16'd1599;
  localparam logic [VAL_W-1:0] CAPACITY_RST = 16'd5000;

  // action codes
  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // floor(x / 20) == floor(5x / 100) == (x * DB_RECIP) >> DB_SHIFT for 16-bit x
  localparam int          DB_SHIFT = 21;
  localparam logic [16:0] DB_RECIP = 17'd104858;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quo;
  } div_res_t;

endpackage
`default_nettype wire

// ----- rtl/bbcs_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. Caller guarantees the
// quotient fits in VAL_W bits (upper dividend half below the divisor).
module bbcs_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [2*bbcs_pkg::VAL_W-1:0] dividend_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0]   divisor_i,
  output bbcs_pkg::div_res_t               res_o
);
  import bbcs_pkg::*;

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] lo_q, lo_d;
  logic [VAL_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [VAL_W:0]   trial;
  logic             fits;

  // shared shift/subtract unit
  assign trial = {rem_q, lo_q[VAL_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i[2*VAL_W-1:VAL_W];
      lo_d  = dividend_i[VAL_W-1:0];
      dvs_d = divisor_i;
      cnt_d = CNT_W'(VAL_W);
    end else if (cnt_q != '0) begin
      rem_d = fits ? VAL_W'(trial - {1'b0, dvs_q}) : trial[VAL_W-1:0];
      lo_d  = {lo_q[VAL_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quo  = lo_q;

endmodule
`default_nettype wire

// ----- rtl/bbcs_step.sv -----
`default_nettype none
// One control step on the levels, plus clamped duty view of the result.
module bbcs_step #(
  parameter int DUTY_BITS = bbcs_pkg::DUTY_BITS_DEF
) (
  input  wire logic [bbcs_pkg::VAL_W-1:0] target_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0] meas_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0] deadband_i,
  input  wire logic [DUTY_BITS-1:0]       period_i,
  input  wire logic [DUTY_BITS-1:0]       buck_i,
  input  wire logic [DUTY_BITS-1:0]       boost_i,
  output logic      [DUTY_BITS-1:0]       buck_o,
  output logic      [DUTY_BITS-1:0]       boost_o,
  output logic      [bbcs_pkg::VAL_W-1:0] buck_duty_o,
  output logic      [bbcs_pkg::VAL_W-1:0] boost_duty_o
);
  import bbcs_pkg::*;

  localparam int CW = (DUTY_BITS > VAL_W) ? DUTY_BITS : VAL_W;

  logic [VAL_W:0]     upper;
  logic               go_up, go_down;
  logic [DUTY_BITS-1:0] half, boost_inc, bk_c, bs_c;
  logic [CW-1:0]      bk_w, bs_w;

  assign upper     = {1'b0, meas_i} + {1'b0, deadband_i};
  assign go_up     = {1'b0, target_i} > upper;
  assign go_down   = target_i < meas_i;
  assign half      = period_i >> 1;
  assign boost_inc = boost_i + 1'b1;

  always_comb begin
    buck_o  = buck_i;
    boost_o = boost_i;
    if (go_up) begin
      if (buck_i == period_i) begin
        boost_o = (boost_inc > half) ? half : boost_inc;
      end else begin
        buck_o = (buck_i >= period_i) ? period_i : buck_i + 1'b1;
      end
    end else if (go_down) begin
      if (buck_i == period_i && boost_i != '0) begin
        boost_o = boost_i - 1'b1;
      end else if (buck_i != '0) begin
        buck_o = buck_i - 1'b1;
      end
    end
  end

  assign bk_c = (buck_o > period_i) ? period_i : buck_o;
  assign bs_c = (boost_o > half) ? half : boost_o;
  assign bk_w = CW'(bk_c);
  assign bs_w = CW'(bs_c);
  assign buck_duty_o  = bk_w[VAL_W-1:0];
  assign boost_duty_o = bs_w[VAL_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/buck_boost_current_stepper.sv -----
// Input transfer to out_valid_o: a divided set passes seed, divider (incl. done flag),
//   deadband, step; a set without a divide skips the divider; a step runs deadband, step.
// Flow control: one item at a time, in_ready_o only in idle; a divided set waits on the
//   16-iteration bit-serial divider, and a stalled result adds its stall.
// Reset (rst_ni low, async): levels, target and drive enable cleared,
//   period_top = 1599, capacity_limit = 5000, no output pending.
`default_nettype none
module buck_boost_current_stepper #(
  parameter int DUTY_BITS = bbcs_pkg::DUTY_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [bbcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           action_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0]     requested_current_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0]     battery_volts_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0]     supply_volts_i,
  input  wire logic [bbcs_pkg::VAL_W-1:0]     measured_current_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [bbcs_pkg::VAL_W-1:0]     buck_duty_o,
  output logic      [bbcs_pkg::VAL_W-1:0]     boost_duty_o,
  output logic                                drive_enabled_o
);
  import bbcs_pkg::*;

  localparam int CW = (DUTY_BITS > VAL_W) ? DUTY_BITS : VAL_W;
  localparam int PW = 2 * VAL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;  // clamp target, pick seed or start divide
  localparam logic [2:0] S_DIV  = 3'd2;  // wait for the divider
  localparam logic [2:0] S_DB   = 3'd3;  // deadband = target / 20
  localparam logic [2:0] S_STEP = 3'd4;  // apply step and load result

  logic [2:0]           state_q, state_d;

  // config registers
  logic [VAL_W-1:0]     period_q, capacity_q;

  // captured item
  logic [VAL_W-1:0]     req_q, bv_q, sv_q, meas_q;

  // regulator state
  logic [VAL_W-1:0]     target_q, target_d;
  logic [DUTY_BITS-1:0] buck_q, buck_d;
  logic [DUTY_BITS-1:0] boost_q, boost_d;
  logic                 on_q, on_d;
  logic [VAL_W-1:0]     db_q, db_d;

  // result register
  logic                 ov_q, ov_d;
  logic [VAL_W-1:0]     obuck_q, obuck_d, oboost_q, oboost_d;
  logic                 oen_q, oen_d;

  // effective period: period_top clamped to the level range
  logic [CW-1:0]        per_ext, mask_ext, per_c;
  logic [DUTY_BITS-1:0] per_l;
  logic [VAL_W-1:0]     per_v;

  assign per_ext  = CW'(period_q);
  assign mask_ext = CW'({DUTY_BITS{1'b1}});
  assign per_c    = (per_ext > mask_ext) ? mask_ext : per_ext;
  assign per_l    = per_c[DUTY_BITS-1:0];
  assign per_v    = per_c[VAL_W-1:0];

  // seed product feeds the divider's registers directly
  logic [PW-1:0]        prod;
  logic                 div_start;
  div_res_t             div_res;
  logic [CW-1:0]        quo_ext;

  assign prod    = PW'(per_v) * PW'(bv_q);
  assign quo_ext = CW'(div_res.quo);

  bbcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (sv_q),
    .res_o      (div_res)
  );

  // deadband by reciprocal multiply
  logic [VAL_W+16:0]    db_prod;
  assign db_prod = (VAL_W+17)'(target_q) * (VAL_W+17)'(DB_RECIP);

  // control step
  logic [DUTY_BITS-1:0] buck_nx, boost_nx;
  logic [VAL_W-1:0]     bduty, qduty;

  bbcs_step #(.DUTY_BITS(DUTY_BITS)) u_step (
    .target_i     (target_q),
    .meas_i       (meas_q),
    .deadband_i   (db_q),
    .period_i     (per_l),
    .buck_i       (buck_q),
    .boost_i      (boost_q),
    .buck_o       (buck_nx),
    .boost_o      (boost_nx),
    .buck_duty_o  (bduty),
    .boost_duty_o (qduty)
  );

  logic in_xfer, out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !ov_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    target_d  = target_q;
    buck_d    = buck_q;
    boost_d   = boost_q;
    on_d      = on_q;
    db_d      = db_q;
    div_start = 1'b0;
    ov_d      = ov_q && !out_ready_i;
    obuck_d   = obuck_q;
    oboost_d  = oboost_q;
    oen_d     = oen_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (action_i == ACT_SET) ? S_SEED : S_DB;
        end
      end
      S_SEED: begin
        on_d     = 1'b1;
        target_d = (req_q > capacity_q) ? capacity_q : req_q;
        if (bv_q > sv_q) begin
          buck_d  = per_l;
          state_d = S_DB;
        end else if (sv_q == '0) begin
          buck_d  = '0;
          state_d = S_DB;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          buck_d  = quo_ext[DUTY_BITS-1:0];
          state_d = S_DB;
        end
      end
      S_DB: begin
        db_d    = VAL_W'(db_prod >> DB_SHIFT);
        state_d = S_STEP;
      end
      S_STEP: begin
        // hold until the result register is free
        if (out_free) begin
          buck_d   = buck_nx;
          boost_d  = boost_nx;
          ov_d     = 1'b1;
          obuck_d  = bduty;
          oboost_d = qduty;
          oen_d    = on_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      period_q   <= PERIOD_RST;
      capacity_q <= CAPACITY_RST;
      target_q   <= '0;
      buck_q     <= '0;
      boost_q    <= '0;
      on_q       <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      target_q <= target_d;
      buck_q   <= buck_d;
      boost_q  <= boost_d;
      on_q     <= on_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PERIOD:   period_q   <= cfg_data_i;
          REG_CAPACITY: capacity_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q  <= requested_current_i;
      bv_q   <= battery_volts_i;
      sv_q   <= supply_volts_i;
      meas_q <= measured_current_i;
    end
    db_q     <= db_d;
    obuck_q  <= obuck_d;
    oboost_q <= oboost_d;
    oen_q    <= oen_d;
  end

  assign out_valid_o     = ov_q;
  assign buck_duty_o     = obuck_q;
  assign boost_duty_o    = oboost_q;
  assign drive_enabled_o = oen_q;

endmodule
`default_nettype wire

// ----- rtl/bbcs_checker.sv -----
`default_nettype none
module bbcs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_we_i,
  input wire logic [bbcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [bbcs_pkg::VAL_W-1:0]     cfg_data_i,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [bbcs_pkg::VAL_W-1:0]     buck_duty_o,
  input wire logic [bbcs_pkg::VAL_W-1:0]     boost_duty_o,
  input wire logic                           drive_enabled_o
);
  import bbcs_pkg::*;

  logic [VAL_W-1:0] per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q <= PERIOD_RST;
    end else if (cfg_we_i && cfg_idx_i == REG_PERIOD) begin
      per_q <= cfg_data_i;
    end
  end

  // one item at a time: not ready right after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after input transfer");

  // buck duty stays within the programmed period, boost duty within half of it
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> buck_duty_o <= per_q && boost_duty_o <= (per_q >> 1))
    else $error("duty out of range");

  // a result cannot appear without a prior input transfer having left idle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> !$past(in_ready_o))
    else $error("result without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(buck_duty_o)
      && $stable(boost_duty_o) && $stable(drive_enabled_o))
    else $error("stalled result changed");

endmodule

bind buck_boost_current_stepper bbcs_checker u_bbcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_idx_i       (cfg_idx_i),
  .cfg_data_i      (cfg_data_i),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .buck_duty_o     (buck_duty_o),
  .boost_duty_o    (boost_duty_o),
  .drive_enabled_o (drive_enabled_o)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbcs_pkg::*;

  // Per-cycle odds (percent) that a side holds off: sender drops valid,
  // receiver drops ready.
  localparam int IDLE_PCT = 18;
  // Items per random phase; six phases give about 900 transfers.
  localparam int PHASE_ITEMS = 150;
  localparam int PHASES = 6;
  // Slowest run is about 900 items plus gaps and stalls, well inside this limit;
  // past it the run is called hung.
  localparam int LIMIT_NS = 2_000_000;

  typedef struct packed {
    logic [VAL_W-1:0] buck;
    logic [VAL_W-1:0] boost;
    logic             en;
  } duty_t;

  typedef struct packed {
    logic             act;
    logic [VAL_W-1:0] req;
    logic [VAL_W-1:0] bv;
    logic [VAL_W-1:0] sv;
    logic [VAL_W-1:0] meas;
  } charge_req_t;

  // Directed rows either write a register or send one charger request.
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [VAL_W-1:0]     reg_val;
    charge_req_t          item;
    logic                 chk;   // 1: expected duties typed in below
    duty_t                want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VAL_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 action_i;
  logic [VAL_W-1:0]     requested_current_i;
  logic [VAL_W-1:0]     battery_volts_i;
  logic [VAL_W-1:0]     supply_volts_i;
  logic [VAL_W-1:0]     measured_current_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [VAL_W-1:0]     buck_duty_o;
  logic [VAL_W-1:0]     boost_duty_o;
  logic                 drive_enabled_o;

  buck_boost_current_stepper dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .requested_current_i (requested_current_i),
    .battery_volts_i     (battery_volts_i),
    .supply_volts_i      (supply_volts_i),
    .measured_current_i  (measured_current_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .buck_duty_o         (buck_duty_o),
    .boost_duty_o        (boost_duty_o),
    .drive_enabled_o     (drive_enabled_o)
  );

  // ---------------------------------------------------------------------------
  // Regulator shadow state: registers plus the four state words of the block.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] period_reg;
  logic [VAL_W-1:0] cap_reg;
  logic [VAL_W-1:0] tgt_ma;
  logic [VAL_W-1:0] buck_lvl;
  logic [VAL_W-1:0] boost_lvl;
  logic             drive_on;

  duty_t duty_queue[$];   // duties still owed by the block, oldest first

  int fail_count = 0;
  int set_count  = 0;
  int step_count = 0;
  int duty_count = 0;
  int reg_count  = 0;
  bit quiet      = 1'b0;  // no hold-offs on either side while set

  // Apply one accepted request to the shadow state, return the duties.
  function automatic duty_t predict_duties(input charge_req_t it);
    logic [VAL_W-1:0] half;
    logic [31:0]      upper;
    duty_t            d;
    if (it.act == ACT_SET) begin
      drive_on = 1'b1;
      tgt_ma   = (it.req > cap_reg) ? cap_reg : it.req;
      // seed buck from the voltage ratio
      if (it.bv > it.sv) buck_lvl = period_reg;
      else if (it.sv == '0) buck_lvl = '0;
      else buck_lvl = VAL_W'((32'(period_reg) * 32'(it.bv)) / 32'(it.sv));
    end
    half  = period_reg >> 1;
    // 5% deadband on the upward side only
    upper = 32'(it.meas) + (32'd5 * 32'(tgt_ma)) / 32'd100;
    if (32'(tgt_ma) > upper) begin
      if (buck_lvl == period_reg) begin
        boost_lvl = boost_lvl + 1'b1;   // wraps at level width
        if (boost_lvl > half) boost_lvl = half;
      end else if (buck_lvl >= period_reg) begin
        buck_lvl = period_reg;           // period dropped under buck
      end else begin
        buck_lvl = buck_lvl + 1'b1;
      end
    end else if (tgt_ma < it.meas) begin
      if (buck_lvl == period_reg) begin
        if (boost_lvl != '0) boost_lvl = boost_lvl - 1'b1;
        else if (buck_lvl != '0) buck_lvl = buck_lvl - 1'b1;
      end else if (buck_lvl != '0) begin
        buck_lvl = buck_lvl - 1'b1;
      end
    end
    // levels are kept, only the reported duty is clamped
    d.buck  = (buck_lvl > period_reg) ? period_reg : buck_lvl;
    d.boost = (boost_lvl > half) ? half : boost_lvl;
    d.en    = drive_on;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Valid is only lowered when a gap is taken or before a drain,
  // so it never sees two updates in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input charge_req_t it, input logic chk, input duty_t want);
    duty_t pred;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    action_i            <= it.act;
    requested_current_i <= it.req;
    battery_volts_i     <= it.bv;
    supply_volts_i      <= it.sv;
    measured_current_i  <= it.meas;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // transfer happened at this edge
    pred = predict_duties(it);
    duty_queue.push_back(chk ? want : pred);
    if (it.act == ACT_SET) set_count++;
    else step_count++;
  endtask

  // Stop sending and wait for every owed result; the block is idle after.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_PERIOD) period_reg = val;
    else cap_reg = val;
    reg_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Typed expectations where the answer is obvious: reset
  // state, drive disabled, zero supply, full clamps, zero period saturation.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [26] = '{
    // drive still off after reset: steps hold at zero
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd0},
      1'b1, '{16'd0, 16'd0, 1'b0}},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd65535},
      1'b1, '{16'd0, 16'd0, 1'b0}},
    // battery above supply: buck at full period, step goes into boost
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd65535, 16'd65535, 16'd0, 16'd0},
      1'b1, '{16'd1599, 16'd1, 1'b1}},
    // zero supply: seed is 0
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd1000, 16'd0, 16'd0, 16'd65535},
      1'b1, '{16'd0, 16'd1, 1'b1}},
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd2000, 16'd1000, 16'd2000, 16'd0}, 1'b0, '0},
    // right on the deadband edge, then one below it
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd2000, 16'd65535, 16'd65535, 16'd1900}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd1899}, 1'b0, '0},
    // walk down through boost and then buck
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd2001}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd2001}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd2001}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd2000}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd0, 16'd12345, 16'd54321, 16'd0}, 1'b0, '0},
    '{ROW_REG, REG_PERIOD, 16'd65535, '0, 1'b0, '0},
    '{ROW_REG, REG_CAPACITY, 16'd65535, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd65535, 16'd65535, 16'd65535, 16'd0},
      1'b1, '{16'd65535, 16'd1, 1'b1}},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd65535}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd65535, 16'd1, 16'd65535, 16'd0}, 1'b0, '0},
    // buck seeded at 65535, then period drops under it
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd3000, 16'd2, 16'd1, 16'd0}, 1'b0, '0},
    '{ROW_REG, REG_PERIOD, 16'd100, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd3000}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    // zero period: down-steps saturate at 0
    '{ROW_REG, REG_PERIOD, 16'd0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd65535}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_SET, 16'd5, 16'd0, 16'd7, 16'd65535}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd65535}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd65535},
      1'b1, '{16'd0, 16'd0, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // Clock, receiver stalls, result checking, watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin : duty_check
    duty_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (duty_queue.size() == 0) begin
        $error("result transfer with nothing expected: buck %0d boost %0d en %0b",
               buck_duty_o, boost_duty_o, drive_enabled_o);
        fail_count++;
      end else begin
        want = duty_queue.pop_front();
        duty_count++;
        if (buck_duty_o !== want.buck) begin
          $error("buck_duty: expected %0d, got %0d", want.buck, buck_duty_o);
          fail_count++;
        end
        if (boost_duty_o !== want.boost) begin
          $error("boost_duty: expected %0d, got %0d", want.boost, boost_duty_o);
          fail_count++;
        end
        if (drive_enabled_o !== want.en) begin
          $error("drive_enabled: expected %0b, got %0b", want.en, drive_enabled_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d results still owed", duty_queue.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, then six random phases, each under
  // its own register setting.
  // ---------------------------------------------------------------------------
  initial begin
    charge_req_t it;
    int          band;
    int          mtry;
    int          roll;
    // all inputs known from time zero
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_PERIOD;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    out_ready_i         = 1'b0;
    action_i            = ACT_STEP;
    requested_current_i = '0;
    battery_volts_i     = '0;
    supply_volts_i      = '0;
    measured_current_i  = '0;
    period_reg          = PERIOD_RST;
    cap_reg             = CAPACITY_RST;
    tgt_ma              = '0;
    buck_lvl            = '0;
    boost_lvl           = '0;
    drive_on            = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_PERIOD, PERIOD_RST);
          write_reg(REG_CAPACITY, CAPACITY_RST);
        end
        1: begin
          // short period: buck saturates fast, boost gets exercised
          write_reg(REG_PERIOD, VAL_W'($urandom_range(40, 1)));
          write_reg(REG_CAPACITY, VAL_W'($urandom));
        end
        2: begin
          // low extremes, and the stretch with no hold-offs
          write_reg(REG_PERIOD, 16'd1);
          write_reg(REG_CAPACITY, 16'd0);
          quiet = 1'b1;
        end
        3: begin
          quiet = 1'b0;
          write_reg(REG_PERIOD, 16'hFFFF);
          write_reg(REG_CAPACITY, 16'hFFFF);
        end
        4: begin
          write_reg(REG_PERIOD, VAL_W'($urandom));
          write_reg(REG_CAPACITY, VAL_W'($urandom));
        end
        default: begin
          write_reg(REG_PERIOD, VAL_W'($urandom_range(300, 2)));
          write_reg(REG_CAPACITY, VAL_W'($urandom_range(20000, 200)));
        end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.act = ($urandom_range(99) < 15) ? ACT_SET : ACT_STEP;
        it.req = ($urandom_range(1)) ? VAL_W'($urandom) : VAL_W'($urandom_range(cap_reg));
        roll = $urandom_range(99);
        if (roll < 10) begin
          it.sv = '0;
          it.bv = VAL_W'($urandom);
        end else if (roll < 35) begin
          it.bv = VAL_W'($urandom);
          it.sv = VAL_W'($urandom);
        end else begin
          it.sv = VAL_W'($urandom);
          it.bv = VAL_W'($urandom_range(it.sv));
        end
        // mostly hover around the target so up, hold and down all show up;
        // a set changes the target, so aim at the clamped request then
        mtry = int'((it.act == ACT_SET) ? ((it.req > cap_reg) ? cap_reg : it.req) : tgt_ma);
        if ($urandom_range(99) < 25) begin
          it.meas = VAL_W'($urandom);
        end else begin
          band = mtry / 20;
          mtry = mtry + int'($urandom_range(band + 8)) - band - 4;
          if (mtry < 0) mtry = 0;
          if (mtry > 65535) mtry = 65535;
          it.meas = VAL_W'(mtry);
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain_results();
    repeat (30) @(posedge clk_i);

    $display("covered %0d set and %0d step transfers, %0d results compared",
             set_count, step_count, duty_count);
    $display("%0d register writes, periods 0/1/100/full and zero/full capacity incl.",
             reg_count);
    if (fail_count == 0 && duty_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
